>>> hdl/dsd_pkg.sv
// Package for the decimal scan display driver: widths, codes, segment map,
// controller/datapath command and status structs. No dependencies.
package dsd_pkg;

    localparam int NUM_DIGITS_DEF = 8;
    localparam int DEC_DIGITS     = 5;
    localparam int BIN_W          = 16;
    localparam int BCD_W          = 4 * DEC_DIGITS;
    localparam int CODE_W         = 8;
    localparam int BITCNT_W       = $clog2(BIN_W);
    localparam int DATA_W         = 2 * CODE_W;

    localparam logic [CODE_W-1:0] BLANK_CODE = 8'hFF;
    localparam logic [CODE_W-1:0] SEL_FIRST  = 8'h80;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // active-low common-anode segment codes
    function automatic logic [CODE_W-1:0] seg_encode(input logic [3:0] digit);
        logic [CODE_W-1:0] code;
        case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = BLANK_CODE;
        endcase
        return code;
    endfunction

    typedef struct packed {
        logic load;
        logic conv_step;
        logic store;
        logic search_step;
        logic emit;
    } dsd_cmd_t;

    typedef struct packed {
        logic in_tick;
        logic conv_last;
        logic hit;
        logic probe_last;
        logic out_free;
    } dsd_stat_t;

endpackage

>>> hdl/decimal_scan_display_8digit.sv
// Top level of the decimal scan display driver.
// Depends on dsd_pkg, dsd_ctrl and dsd_datapath.
//
// Input channel s_*: s_tuser is the command (0 = load, 1 = scan tick),
// s_tdata is the 16-bit binary value, used on a load only.
// Output channel m_*: one item per scan tick, none per load; m_tdata holds
// the one-hot digit select (bit 7 = position 0) and the inverted segment code.
// cfg_we/cfg_wdata write skip_blank (1 skips blank positions while scanning).
// A load converts the value one bit per cycle: accept, 16 shift-add-3 steps,
// code write. A tick probes one position per cycle from the scan position,
// all blank in skip mode giving a zero item; once the result is registered,
// the block is idle for the next item.
// One item is in work at a time; s_tready is high only when idle.
// A finished result waits in the output register while the next item is
// taken; a tick whose result is ready holds until that register is free.
// Reset: all digits blank, scan position 0, skip_blank 1, output empty.
module decimal_scan_display_8digit
    import dsd_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BIN_W-1:0]  s_tdata,   // value
    input  logic              s_tuser,   // cmd
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // digit_select, segments
    input  logic              cfg_we,
    input  logic              cfg_wdata  // skip_blank
);

    dsd_cmd_t  cmd;
    dsd_stat_t stat;

    dsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dsd_datapath #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (s_tdata),
        .in_cmd    (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

`ifndef NO_ASSERTIONS
    // a load never produces an item
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == CMD_LOAD) |=> !$rose(m_tvalid))
        else $error("output appeared after a load");

    // a result is only produced while the input side is busy
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("output rose while input was idle");

    // at most one position, and only a scanned one
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($onehot0(m_tdata[CODE_W-1:0])
                      && ((m_tdata[CODE_W-1:0] & (8'hFF >> NUM_DIGITS)) == 8'h00)))
        else $error("bad digit select");
`endif

endmodule

>>> hdl/dsd_ctrl.sv
// Controller state machine of the scan display driver.
// Depends on dsd_pkg (command and status structs).
module dsd_ctrl
    import dsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dsd_stat_t stat,
    output dsd_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_STORE,
        ST_SEARCH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_tick ? ST_SEARCH : ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (stat.conv_last)
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SEARCH:
            begin
                if (stat.hit || stat.probe_last)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                    cmd.search_step = 1'b1;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> hdl/dsd_datapath.sv
// Datapath: shift-add-3 binary to BCD, digit code store, scan cursor,
// output register. Depends on dsd_pkg; driven by dsd_ctrl.
module dsd_datapath
    import dsd_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BIN_W-1:0]  value,
    input  logic              in_cmd,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [DATA_W-1:0] m_tdata,
    input  dsd_cmd_t          cmd,
    output dsd_stat_t         stat
);

    localparam int POS_W   = $clog2(NUM_DIGITS);
    localparam int CODEI_W = $clog2(DEC_DIGITS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_DIGITS - 1);

    logic [BIN_W-1:0]    bin_reg;
    logic [BCD_W-1:0]    bcd_reg;
    logic [BITCNT_W-1:0] bit_cnt_reg;
    logic [CODE_W-1:0]   codes_reg [DEC_DIGITS];
    logic [POS_W-1:0]    scan_pos_reg;
    logic [POS_W-1:0]    cursor_reg;
    logic [POS_W-1:0]    probe_reg;
    logic                skip_reg;
    logic                m_valid_reg;
    logic [DATA_W-1:0]   m_data_reg;

    logic [BCD_W-1:0]    bcd_adj;
    logic [CODE_W-1:0]   cur_code;
    logic [CODE_W-1:0]   cur_sel;
    logic [POS_W-1:0]    cursor_wrap;
    logic [CODE_W-1:0]   new_codes [DEC_DIGITS];
    logic                lead;

    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // leading zeros above position 0 go blank
    always_comb
    begin
        lead = 1'b1;
        for (int i = DEC_DIGITS - 1; i >= 0; i--)
        begin
            lead = lead && (bcd_reg[4*i +: 4] == 4'd0) && (i > 0);
            new_codes[i] = lead ? BLANK_CODE : seg_encode(bcd_reg[4*i +: 4]);
        end
    end

    assign cursor_wrap = (cursor_reg == POS_LAST) ? '0 : cursor_reg + 1'b1;
    assign cur_code    = (cursor_reg < POS_W'(DEC_DIGITS)) ?
                         codes_reg[cursor_reg[CODEI_W-1:0]] : BLANK_CODE;
    assign cur_sel     = SEL_FIRST >> cursor_reg;

    assign stat.in_tick    = (in_cmd == CMD_TICK);
    assign stat.conv_last  = (bit_cnt_reg == BITCNT_W'(BIN_W - 1));
    assign stat.hit        = !skip_reg || (cur_code != BLANK_CODE);
    assign stat.probe_last = (probe_reg == POS_LAST);
    assign stat.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEC_DIGITS; i++)
                codes_reg[i] <= BLANK_CODE;
            scan_pos_reg <= '0;
            skip_reg     <= 1'b1;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                skip_reg <= cfg_wdata;
            if (cmd.store)
            begin
                for (int i = 0; i < DEC_DIGITS; i++)
                    codes_reg[i] <= new_codes[i];
            end
            if (cmd.emit)
            begin
                m_valid_reg <= 1'b1;
                if (stat.hit)
                    scan_pos_reg <= cursor_wrap;
            end
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg     <= value;
            bcd_reg     <= '0;
            bit_cnt_reg <= '0;
            cursor_reg  <= scan_pos_reg;
            probe_reg   <= '0;
        end
        if (cmd.conv_step)
        begin
            bcd_reg     <= {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_reg     <= {bin_reg[BIN_W-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + 1'b1;
        end
        if (cmd.search_step)
        begin
            cursor_reg <= cursor_wrap;
            probe_reg  <= probe_reg + 1'b1;
        end
        if (cmd.emit)
            m_data_reg <= stat.hit ? {~cur_code, cur_sel} : '0;
    end

endmodule

>>> tb/sv/tb_scan_pkg.sv
// Scoreboard class for the decimal scan display driver testbench.
// Predicts digit codes, scan position and each scan tick's output item.
// Depends on dsd_pkg.
package tb_scan_pkg;
    import dsd_pkg::*;

    localparam logic [7:0] DIGIT_MAP [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    typedef struct packed {
        logic [7:0] segments;
        logic [7:0] digit_select;
    } scan_out_t;

    class scan_scoreboard;
        logic [7:0] codes [NUM_DIGITS_DEF];
        int         scan_pos;
        logic       skip_blank;
        scan_out_t  pending_out [$];
        int         n_loads;
        int         n_ticks;
        int         n_dark;
        int         n_checked;
        int         n_errors;

        function new();
            foreach (codes[i])
                codes[i] = BLANK_CODE;
            scan_pos   = 0;
            skip_blank = 1'b1;
            n_loads    = 0;
            n_ticks    = 0;
            n_dark     = 0;
            n_checked  = 0;
            n_errors   = 0;
        endfunction

        function void write_skip(logic v);
            skip_blank = v;
        endfunction

        function int pending();
            return pending_out.size();
        endfunction

        function void note_item(logic cmd, logic [15:0] value);
            logic [15:0] v;
            scan_out_t   res;
            int          p;
            int          i;
            bit          found;
            if (cmd == CMD_LOAD)
            begin
                n_loads++;
                v = value;
                for (i = 0; i < 5; i++)
                begin
                    codes[i] = DIGIT_MAP[v % 10];
                    v = v / 10;
                end
                // leading zeros blanked down to position 1
                for (i = 4; i >= 1; i--)
                begin
                    if (codes[i] != DIGIT_MAP[0])
                        break;
                    codes[i] = BLANK_CODE;
                end
                return;
            end
            n_ticks++;
            p     = scan_pos;
            found = 1'b0;
            res   = '0;
            for (i = 0; i < NUM_DIGITS_DEF && !found; i++)
            begin
                if (!skip_blank || codes[p] != BLANK_CODE)
                begin
                    res.digit_select = SEL_FIRST >> p;
                    res.segments     = ~codes[p];
                    scan_pos         = (p + 1) % NUM_DIGITS_DEF;
                    found            = 1'b1;
                end
                else
                    p = (p + 1) % NUM_DIGITS_DEF;
            end
            if (!found)
                n_dark++;
            pending_out.push_back(res);
        endfunction

        function void check_result(logic [15:0] data);
            scan_out_t got;
            scan_out_t want;
            got = data;
            if (pending_out.size() == 0)
            begin
                $error("unexpected item: digit_select %h segments %h",
                       got.digit_select, got.segments);
                n_errors++;
                return;
            end
            want = pending_out.pop_front();
            n_checked++;
            if (got.digit_select !== want.digit_select)
            begin
                $error("digit_select: expected %h, actual %h",
                       want.digit_select, got.digit_select);
                n_errors++;
            end
            if (got.segments !== want.segments)
            begin
                $error("segments: expected %h, actual %h",
                       want.segments, got.segments);
                n_errors++;
            end
        endfunction
    endclass

endpackage

>>> tb/sv/tb_top.sv
// Top of the decimal scan display driver testbench: clock, reset, stream
// drivers, random backpressure and watchdog. Depends on dsd_pkg, tb_scan_pkg
// and decimal_scan_display_8digit.
module tb_top;
    import dsd_pkg::*;
    import tb_scan_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 30;
    localparam int RAND_PHASE_ITEMS = 220;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BIN_W-1:0]  s_tdata = '0;    // value
    logic              s_tuser = CMD_TICK;  // cmd
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;         // digit_select, segments
    logic              cfg_we = 1'b0;
    logic              cfg_wdata = 1'b0;  // skip_blank

    logic quiet = 1'b0;
    int   idle_count = 0;
    int   n_settings = 0;

    scan_scoreboard board = new();

    decimal_scan_display_8digit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // output side: random stall bursts until the last phase
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic put(logic cmd, logic [15:0] value);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_item(cmd, value);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        // a trailing load may still be converting
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_skip(logic v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.write_skip(v);
        n_settings++;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 9));
            1:       return 16'($urandom_range(10, 99));
            2:       return 16'($urandom_range(100, 9999) / 10 * 10);
            3:       return 16'($urandom_range(0, 9) * 10000);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_phase(int count);
        logic cmd;
        for (int i = 0; i < count; i++)
        begin
            cmd = ($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_TICK;
            put(cmd, (cmd == CMD_LOAD) ? pick_value() : 16'($urandom_range(0, 65535)));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // skip mode from reset: all dark, single digit, wrap of the search
        n_settings++;
        put(CMD_TICK, 16'hFFFF);
        put(CMD_LOAD, 16'd0);
        put(CMD_TICK, 16'h0000);
        put(CMD_TICK, 16'h0000);
        put(CMD_LOAD, 16'hFFFF);
        repeat (6) put(CMD_TICK, 16'h0000);

        // full scan: blank positions driven dark, inner zeros kept
        set_skip(1'b0);
        put(CMD_LOAD, 16'd10000);
        repeat (9) put(CMD_TICK, 16'h0000);
        put(CMD_LOAD, 16'd100);
        repeat (3) put(CMD_TICK, 16'h0000);

        set_skip(1'b1);
        random_phase(RAND_PHASE_ITEMS);
        set_skip(1'b0);
        random_phase(RAND_PHASE_ITEMS);
        set_skip(1'b1);
        random_phase(RAND_PHASE_ITEMS);
        set_skip(1'b0);
        quiet = 1'b1;
        random_phase(RAND_PHASE_ITEMS);

        drain();
        $display("Ran %0d loads and %0d scan ticks (%0d all-dark) over %0d skip settings;",
                 board.n_loads, board.n_ticks, board.n_dark, n_settings);
        $display("%0d output items checked, %0d errors", board.n_checked, board.n_errors);
        if (board.n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
